/* rtl/bpes_pkg.sv */
`timescale 1ns / 1ps
// bpes_pkg: shared constants and types for the base pairing energy score block
// depends on nothing; imported by base_pairing_energy_score_top and the testbench

package bpes_pkg;

    // stream field widths
    localparam int DIST_W   = 16;
    localparam int NDIST    = 9;
    localparam int TYPE_W   = 2;
    localparam int ENERGY_W = 40;
    localparam int STATUS_W = 2;

    // configuration port
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;
    localparam int ROW_W      = 48;
    localparam int WEIGHT_W   = 16;

    // register indexes (byte address is 8 times the index)
    localparam logic [1:0] REG_REF_ROW0    = 2'd0;
    localparam logic [1:0] REG_REF_ROW1    = 2'd1;
    localparam logic [1:0] REG_REF_ROW2    = 2'd2;
    localparam logic [1:0] REG_PAIR_WEIGHT = 2'd3;

    localparam logic signed [WEIGHT_W-1:0] WEIGHT_RESET = 16'sd256;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_SCORED    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_WINDOW    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DEVIATION = 2'd2;

    // distance windows, raw q8.8, both bounds open
    localparam logic [DIST_W-1:0] WIN0_LO = 16'd3712;
    localparam logic [DIST_W-1:0] WIN0_HI = 16'd4480;
    localparam logic [DIST_W-1:0] WIN1_LO = 16'd2432;
    localparam logic [DIST_W-1:0] WIN1_HI = 16'd3712;

    // largest deviation magnitude whose square stays at or below one
    localparam logic [DIST_W:0] DEV_LIMIT = 17'd256;

    // internal widths
    localparam int MAG_W   = 9;   // deviation magnitude, at most 256
    localparam int SQ_W    = 17;  // square, at most 65536
    localparam int SUM_W   = 20;  // nine squares
    localparam int BASE_W  = 24;  // -100 + sum in q16.16
    localparam int HALF_W  = 3;   // type factor in halves
    localparam int SCALE_W = 27;  // base times halves
    localparam int PROD_W  = 43;  // scaled base times weight, 25 fraction bits
    localparam int SHIFT   = 9;

    localparam logic signed [BASE_W-1:0] OFFSET_Q16 = -24'sd6553600;

    // type factor in halves: 2, 3, 1 or 0.5
    localparam logic [HALF_W-1:0] HALVES_TWO   = 3'd4;
    localparam logic [HALF_W-1:0] HALVES_THREE = 3'd6;
    localparam logic [HALF_W-1:0] HALVES_ONE   = 3'd2;
    localparam logic [HALF_W-1:0] HALVES_HALF  = 3'd1;

    // side information that rides along with each beat in the pipeline
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HALF_W-1:0]   halves;
    } bpes_ctl_t;

endpackage

/* rtl/base_pairing_energy_score_top.sv */
`timescale 1ns / 1ps
// base_pairing_energy_score_top: five-stage pipelined pairing energy scorer
// depends on bpes_pkg
//
// usage
//   input stream (s_*): one beat carries a 3x3 q8.8 distance matrix in s_tdata
//   and both base types in s_tuser. output stream (m_*): one beat per input beat,
//   energy (signed, 16 fraction bits) in m_tdata and status in m_tuser
//   (0 scored, 1 outside distance window, 2 deviation above one, energy 0 then).
//   the apb port holds three reference rows and the signed q8.8 weight at byte
//   addresses 0, 8, 16 and 24; write it only while the stream is idle.
// throughput
//   one beat per cycle sustained while m_tready stays high.
//   stages: deviations and window check, squares, sum, type factor, weight
//   multiply; the 27x16 weight multiplier sets the longest stage.
// reset
//   rst_n clears all valid bits and loads the reset register values
//   (rows zero, weight 1.0); beats still in flight at reset are dropped.
// stalls
//   each stage holds its beat while the next is full and stalled, and empty
//   stages keep filling, so s_tready drops only when all five stages are full.

module base_pairing_energy_score_top
    import bpes_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    // input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // dist_00, dist_01, dist_02, dist_10, dist_11, dist_12, dist_20, dist_21, dist_22
    input  logic [NDIST*DIST_W-1:0]   s_tdata,
    // first_type, second_type
    input  logic [2*TYPE_W-1:0]       s_tuser,

    // output stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // energy
    output logic [ENERGY_W-1:0]       m_tdata,
    // status
    output logic [STATUS_W-1:0]       m_tuser,

    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [CFG_ADDR_W-1:0]     paddr,
    input  logic [CFG_DATA_W-1:0]     pwdata,
    output logic [CFG_DATA_W-1:0]     prdata,
    output logic                      pready
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [ROW_W-1:0]           ref_row_reg [3];
    logic signed [WEIGHT_W-1:0] weight_reg;
    logic                       cfg_write;
    logic [1:0]                 cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_index = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_row_reg[0] <= '0;
            ref_row_reg[1] <= '0;
            ref_row_reg[2] <= '0;
            weight_reg     <= WEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_REF_ROW0:    ref_row_reg[0] <= pwdata[ROW_W-1:0];
                REG_REF_ROW1:    ref_row_reg[1] <= pwdata[ROW_W-1:0];
                REG_REF_ROW2:    ref_row_reg[2] <= pwdata[ROW_W-1:0];
                REG_PAIR_WEIGHT: weight_reg     <= $signed(pwdata[WEIGHT_W-1:0]);
                default:         ;
            endcase
        end
    end

    // read back, rows zero extended, weight sign extended
    always_comb
    begin
        unique case (cfg_index)
            REG_REF_ROW0:    prdata = CFG_DATA_W'(ref_row_reg[0]);
            REG_REF_ROW1:    prdata = CFG_DATA_W'(ref_row_reg[1]);
            REG_REF_ROW2:    prdata = CFG_DATA_W'(ref_row_reg[2]);
            REG_PAIR_WEIGHT: prdata = CFG_DATA_W'(weight_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline handshake: a stage takes a new beat when empty or when the
    // stage after it moves on
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5     = !v5_reg || m_tready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: deviations against the (possibly transposed) reference,
    // window check, type factor
    // ------------------------------------------------------------------
    logic [TYPE_W-1:0] first_type, second_type;
    logic              transpose;
    logic [DIST_W-1:0] dist_in [NDIST];
    logic [DIST_W-1:0] ref_d  [NDIST];
    logic [NDIST-1:0]  over;
    logic [MAG_W-1:0]  mag    [NDIST];
    logic              in_window;
    logic [TYPE_W:0]   type_sum;
    bpes_ctl_t         ctl1_next;

    assign first_type  = s_tuser[TYPE_W-1:0];
    assign second_type = s_tuser[2*TYPE_W-1:TYPE_W];
    // first types 1 and 3 read the reference column by column
    assign transpose   = first_type[0];

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar c = 0; c < 3; c++)
        begin : g_col
            logic signed [DIST_W:0] diff;
            logic [DIST_W:0]        absd;

            assign dist_in[r*3+c] = s_tdata[(r*3+c)*DIST_W +: DIST_W];
            assign ref_d[r*3+c] = transpose ? ref_row_reg[c][r*DIST_W +: DIST_W]
                                            : ref_row_reg[r][c*DIST_W +: DIST_W];
            assign diff = $signed({1'b0, dist_in[r*3+c]}) - $signed({1'b0, ref_d[r*3+c]});
            assign absd = diff[DIST_W] ? 17'(-diff) : 17'(diff);
            assign over[r*3+c] = absd > DEV_LIMIT;
            assign mag[r*3+c]  = over[r*3+c] ? '0 : absd[MAG_W-1:0];
        end
    end

    assign in_window = (dist_in[0] > WIN0_LO) && (dist_in[0] < WIN0_HI) &&
                       (dist_in[4] > WIN1_LO) && (dist_in[4] < WIN1_HI);
    assign type_sum  = {1'b0, first_type} + {1'b0, second_type};

    always_comb
    begin
        if (!in_window)
            ctl1_next.status = STATUS_WINDOW;
        else if (|over)
            ctl1_next.status = STATUS_DEVIATION;
        else
            ctl1_next.status = STATUS_SCORED;

        // sum one: types 0/1; sum five: types 2/3; product two: types 1/2
        if (type_sum == 3'd1)
            ctl1_next.halves = HALVES_TWO;
        else if (type_sum == 3'd5)
            ctl1_next.halves = HALVES_THREE;
        else if ((first_type == 2'd1 && second_type == 2'd2) ||
                 (first_type == 2'd2 && second_type == 2'd1))
            ctl1_next.halves = HALVES_ONE;
        else
            ctl1_next.halves = HALVES_HALF;
    end

    logic [MAG_W-1:0] mag1_reg [NDIST];
    bpes_ctl_t        ctl1_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            mag1_reg <= mag;
            ctl1_reg <= ctl1_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: nine small squares in parallel
    // ------------------------------------------------------------------
    logic [SQ_W-1:0] sq2_next [NDIST];
    logic [SQ_W-1:0] sq2_reg  [NDIST];
    bpes_ctl_t       ctl2_reg;

    for (genvar k = 0; k < NDIST; k++)
    begin : g_sq
        logic [2*MAG_W-1:0] sq_full;
        assign sq_full     = mag1_reg[k] * mag1_reg[k];
        assign sq2_next[k] = sq_full[SQ_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            sq2_reg  <= sq2_next;
            ctl2_reg <= ctl1_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: sum of squares minus 100 in q16.16
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]         sum3;
    logic signed [BASE_W-1:0] base3_reg;
    bpes_ctl_t                ctl3_reg;

    assign sum3 = ((SUM_W'(sq2_reg[0]) + SUM_W'(sq2_reg[1])) +
                   (SUM_W'(sq2_reg[2]) + SUM_W'(sq2_reg[3]))) +
                  ((SUM_W'(sq2_reg[4]) + SUM_W'(sq2_reg[5])) +
                   (SUM_W'(sq2_reg[6]) + SUM_W'(sq2_reg[7]))) +
                  SUM_W'(sq2_reg[8]);

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            base3_reg <= OFFSET_Q16 + $signed({{(BASE_W-SUM_W){1'b0}}, sum3});
            ctl3_reg  <= ctl2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: type factor in halves
    // ------------------------------------------------------------------
    logic signed [SCALE_W-1:0] scale4_next;
    logic signed [SCALE_W-1:0] scale4_reg;
    bpes_ctl_t                 ctl4_reg;

    assign scale4_next = SCALE_W'(base3_reg) *
                         $signed({{(SCALE_W-HALF_W){1'b0}}, ctl3_reg.halves});

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            scale4_reg <= scale4_next;
            ctl4_reg   <= ctl3_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: weight multiply, drop 9 fraction bits (floor), output register
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] prod5;
    logic [ENERGY_W-1:0]      energy5;
    logic [ENERGY_W-1:0]      energy_reg;
    logic [STATUS_W-1:0]      status_reg;

    assign prod5   = PROD_W'(scale4_reg) * PROD_W'(weight_reg);
    assign energy5 = {{(ENERGY_W-(PROD_W-SHIFT)){prod5[PROD_W-1]}}, prod5[PROD_W-1:SHIFT]};

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            energy_reg <= (ctl4_reg.status == STATUS_SCORED) ? energy5 : '0;
            status_reg <= ctl4_reg.status;
        end
    end

    assign m_tdata = energy_reg;
    assign m_tuser = status_reg;

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench for the base pairing energy scorer, which scores
// random and directed distance matrices against a predictor kept in step with the
// register writes; depends on bpes_pkg and base_pairing_energy_score_top

module testbench;
    import bpes_pkg::*;

    // receiver hold-off used to fill the pipeline and stall the input side
    localparam int HOLD_CYCLES = 300;
    // watchdog: cycles with no beat, no register access and no reset
    localparam int IDLE_LIMIT  = 3000;
    // cycles allowed after the last result before a register write or the end
    localparam int SETTLE      = 8;
    // ready pattern for the patterned receiver, one bit per cycle
    localparam logic [10:0] READY_PATTERN = 11'b110_1001_1101;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

    // one input beat: dmat[0] is dist_00, dmat[8] is dist_22
    typedef struct {
        logic [NDIST-1:0][DIST_W-1:0] dmat;
        logic [TYPE_W-1:0]            first_type;
        logic [TYPE_W-1:0]            second_type;
    } pair_item_t;

    // one output beat
    typedef struct {
        logic signed [ENERGY_W-1:0] energy;
        logic [STATUS_W-1:0]        status;
    } score_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;

    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    // dist_00, dist_01, dist_02, dist_10, dist_11, dist_12, dist_20, dist_21, dist_22
    logic [NDIST*DIST_W-1:0] s_tdata = '0;
    // first_type, second_type
    logic [2*TYPE_W-1:0]     s_tuser = '0;

    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    // energy
    logic [ENERGY_W-1:0]     m_tdata;
    // status
    logic [STATUS_W-1:0]     m_tuser;

    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]   paddr = '0;
    logic [CFG_DATA_W-1:0]   pwdata = '0;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;

    // shadow copy of the register file, updated at each write
    logic [ROW_W-1:0]           row_shadow [3];
    logic signed [WEIGHT_W-1:0] weight_shadow;

    // scores predicted for accepted matrices, oldest first
    score_t pending_scores [$];

    // sender pacing: bursts of random length, random gaps up to gap_max
    int gap_max = 0;
    int burst_left = 0;

    // receiver control
    rx_mode_t rx_mode = RX_OPEN;
    bit hold_request = 1'b0;
    int rx_cycle = 0;

    // bookkeeping
    int n_accepted = 0;
    int n_checked = 0;
    int n_scored = 0;
    int n_window = 0;
    int n_deviation = 0;
    int n_reg_writes = 0;
    int n_errors = 0;
    int idle_cycles = 0;

    base_pairing_energy_score_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // reference entry (row, col) from the shadow rows, column 0 in the low bits
    function automatic logic [DIST_W-1:0] ref_at(input int row, input int col);
        return row_shadow[row][col*DIST_W +: DIST_W];
    endfunction

    // predicted score for one matrix under the current register values
    function automatic score_t score_pair(input pair_item_t it);
        score_t             res;
        logic               swap;
        logic [HALF_W-1:0]  halves;
        longint             diff;
        longint             sq;
        longint             sum;
        longint             prod;
        int                 ta;
        int                 tb;
        res.energy = '0;
        res.status = STATUS_SCORED;
        ta = int'(it.first_type);
        tb = int'(it.second_type);
        // odd first types compare against the transposed reference
        swap = (ta == 1 || ta == 3);
        if (!(it.dmat[0] > WIN0_LO && it.dmat[0] < WIN0_HI &&
              it.dmat[4] > WIN1_LO && it.dmat[4] < WIN1_HI))
        begin
            res.status = STATUS_WINDOW;
            return res;
        end
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                diff = longint'(it.dmat[i*3+j]) -
                       longint'(swap ? ref_at(j, i) : ref_at(i, j));
                sq = diff * diff;
                // a square strictly above one (65536 in q16.16) kills the score
                if (sq > 65536)
                begin
                    res.status = STATUS_DEVIATION;
                    return res;
                end
                sum += sq;
            end
        end
        if (ta + tb == 1)
            halves = HALVES_TWO;
        else if (ta + tb == 5)
            halves = HALVES_THREE;
        else if (ta * tb == 2)
            halves = HALVES_ONE;
        else
            halves = HALVES_HALF;
        // 25 fraction bits, floor down to 16
        prod = (longint'(OFFSET_Q16) + sum) * longint'(halves) * longint'(weight_shadow);
        res.energy = ENERGY_W'(prod >>> SHIFT);
        return res;
    endfunction

    // matrix that matches the reference exactly, transposed where the type asks
    function automatic pair_item_t exact_pair(input logic [TYPE_W-1:0] a,
                                              input logic [TYPE_W-1:0] b);
        pair_item_t it;
        it.first_type = a;
        it.second_type = b;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                it.dmat[i*3+j] = (a == 1 || a == 3) ? ref_at(j, i) : ref_at(i, j);
        return it;
    endfunction

    // well-formed matrix: reference plus bounded deviation, dist_00 and dist_11 kept in window
    function automatic pair_item_t shaped_pair(input int dev_max);
        pair_item_t it;
        int         v;
        it = exact_pair(TYPE_W'($urandom_range(0, 3)), TYPE_W'($urandom_range(0, 3)));
        for (int k = 0; k < NDIST; k++)
        begin
            v = int'(it.dmat[k]) + int'($urandom_range(0, 2 * dev_max)) - dev_max;
            if (v < 0)
                v = 0;
            if (v > 65535)
                v = 65535;
            if (k == 0 && v <= int'(WIN0_LO))
                v = WIN0_LO + 1;
            if (k == 0 && v >= int'(WIN0_HI))
                v = WIN0_HI - 1;
            if (k == 4 && v <= int'(WIN1_LO))
                v = WIN1_LO + 1;
            if (k == 4 && v >= int'(WIN1_HI))
                v = WIN1_HI - 1;
            it.dmat[k] = DIST_W'(v);
        end
        return it;
    endfunction

    // junk and broken matrices: fully random, window miss, one entry far off
    function automatic pair_item_t noisy_pair();
        pair_item_t it;
        int         k;
        it = shaped_pair($urandom_range(0, 256));
        case ($urandom_range(0, 2))
            0:
            begin
                for (k = 0; k < NDIST; k++)
                    it.dmat[k] = DIST_W'($urandom);
                it.first_type = TYPE_W'($urandom_range(0, 3));
                it.second_type = TYPE_W'($urandom_range(0, 3));
            end
            1:
            begin
                if ($urandom_range(0, 1))
                    it.dmat[0] = DIST_W'($urandom_range(0, 1) ? $urandom_range(0, WIN0_LO)
                                                   : $urandom_range(WIN0_HI, 65535));
                else
                    it.dmat[4] = DIST_W'($urandom_range(0, 1) ? $urandom_range(0, WIN1_LO)
                                                   : $urandom_range(WIN1_HI, 65535));
            end
            default:
            begin
                k = $urandom_range(0, NDIST - 1);
                if ($urandom_range(0, 1))
                    it.dmat[k] = DIST_W'(it.dmat[k] + $urandom_range(257, 3000));
                else
                    it.dmat[k] = DIST_W'(it.dmat[k] - $urandom_range(257, 3000));
            end
        endcase
        return it;
    endfunction

    // apb write followed by a read-back of the same register
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] mask;
        mask = (idx == REG_PAIR_WEIGHT) ? CFG_DATA_W'({WEIGHT_W{1'b1}})
                                        : CFG_DATA_W'({ROW_W{1'b1}});
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // register takes the value at this edge
        if (idx == REG_PAIR_WEIGHT)
            weight_shadow = value[WEIGHT_W-1:0];
        else
            row_shadow[idx] = value[ROW_W-1:0];
        n_reg_writes++;
        // read setup, psel stays high
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if ((prdata & mask) !== (value & mask))
        begin
            $error("prdata of register %0d: expected %h, got %h", idx, value & mask,
                   prdata & mask);
            n_errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        // back to idle before the next access
        @(posedge clk);
    endtask

    // reference matrix into the three row registers
    task automatic load_refs(input logic [NDIST-1:0][DIST_W-1:0] m);
        write_reg(REG_REF_ROW0, {16'h0, m[2], m[1], m[0]});
        write_reg(REG_REF_ROW1, {16'h0, m[5], m[4], m[3]});
        write_reg(REG_REF_ROW2, {16'h0, m[8], m[7], m[6]});
    endtask

    // random reference, dist_00 and dist_11 inside the windows; edge values only when asked
    task automatic load_random_refs(input bit edge_values);
        logic [NDIST-1:0][DIST_W-1:0] m;
        for (int k = 0; k < NDIST; k++)
            m[k] = edge_values ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
                               : DIST_W'($urandom);
        m[0] = DIST_W'($urandom_range(WIN0_LO + 1, WIN0_HI - 1));
        m[4] = DIST_W'($urandom_range(WIN1_LO + 1, WIN1_HI - 1));
        load_refs(m);
    endtask

    task automatic write_weight(input logic signed [WEIGHT_W-1:0] w);
        write_reg(REG_PAIR_WEIGHT, {{(CFG_DATA_W-WEIGHT_W){1'b0}}, w});
    endtask

    // offer one matrix and wait for the beat to be taken
    task automatic send_pair(input pair_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= it.dmat;
        s_tuser <= {it.second_type, it.first_type};
        do
            @(posedge clk);
        while (!s_tready);
        pending_scores.push_back(score_pair(it));
        n_accepted++;
    endtask

    // stop sending, let every predicted score come out, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_scores.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // mostly well-formed matrices with a share of junk
    task automatic send_mix(input int count, input int junk_pct);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < junk_pct)
                send_pair(noisy_pair());
            else
                send_pair(shaped_pair($urandom_range(0, 1) ? 256 : $urandom_range(0, 256)));
        end
    endtask

    // reset register values: zero reference, so every windowed matrix over-deviates
    task automatic test_reset_values();
        rx_mode = RX_OPEN;
        gap_max = 0;
        send_mix(10, 50);
        drain();
    endtask

    // window bounds, deviation of exactly one and just above, every type factor
    task automatic test_directed();
        pair_item_t it;
        load_refs({16'd8000, 16'd7000, 16'd6000,
                   16'd5000, 16'd2600, 16'd3000,
                   16'd2000, 16'd1000, 16'd3900});
        write_weight(WEIGHT_RESET);
        rx_mode = RX_OPEN;
        gap_max = 0;
        // factor two, three, one and one half, direct and transposed
        send_pair(exact_pair(2'd0, 2'd1));
        send_pair(exact_pair(2'd1, 2'd0));
        send_pair(exact_pair(2'd2, 2'd3));
        send_pair(exact_pair(2'd3, 2'd2));
        send_pair(exact_pair(2'd1, 2'd2));
        send_pair(exact_pair(2'd2, 2'd1));
        send_pair(exact_pair(2'd0, 2'd0));
        send_pair(exact_pair(2'd3, 2'd3));
        // open window bounds on dist_00 and dist_11
        it = exact_pair(2'd0, 2'd0);
        it.dmat[0] = WIN0_LO;
        send_pair(it);
        it.dmat[0] = DIST_W'(WIN0_LO + 1);
        send_pair(it);
        it.dmat[0] = DIST_W'(WIN0_HI - 1);
        send_pair(it);
        it.dmat[0] = WIN0_HI;
        send_pair(it);
        it = exact_pair(2'd0, 2'd0);
        it.dmat[4] = WIN1_LO;
        send_pair(it);
        it.dmat[4] = DIST_W'(WIN1_LO + 1);
        send_pair(it);
        it.dmat[4] = DIST_W'(WIN1_HI - 1);
        send_pair(it);
        it.dmat[4] = WIN1_HI;
        send_pair(it);
        // deviation of exactly one passes, one step more fails
        it = exact_pair(2'd0, 2'd0);
        it.dmat[5] = DIST_W'(ref_at(1, 2) + 256);
        send_pair(it);
        it.dmat[5] = DIST_W'(ref_at(1, 2) - 256);
        send_pair(it);
        it.dmat[5] = DIST_W'(ref_at(1, 2) + 257);
        send_pair(it);
        it.dmat[5] = DIST_W'(ref_at(1, 2) - 257);
        send_pair(it);
        // all-zero and all-ones matrices
        it.dmat = '0;
        it.first_type = 2'd3;
        it.second_type = 2'd3;
        send_pair(it);
        it.dmat = '1;
        it.first_type = 2'd2;
        it.second_type = 2'd1;
        send_pair(it);
        drain();
    endtask

    // extreme and sign-flipping weights against random references
    task automatic test_weight_extremes();
        logic signed [WEIGHT_W-1:0] weights [5];
        weights = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1};
        foreach (weights[k])
        begin
            load_random_refs(k == 3);
            write_weight(weights[k]);
            rx_mode = RX_RANDOM;
            gap_max = 4;
            send_mix(50, 15);
            drain();
        end
    endtask

    // random register settings, pacing and receiver behavior
    task automatic test_random_mix();
        for (int phase = 0; phase < 10; phase++)
        begin
            load_random_refs($urandom_range(0, 3) == 0);
            write_weight(WEIGHT_W'($urandom));
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            case ($urandom_range(0, 2))
                0: gap_max = 0;
                1: gap_max = 3;
                default: gap_max = 10;
            endcase
            send_mix(100, 20);
            drain();
        end
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        rx_mode = RX_OPEN;
        gap_max = 0;
        hold_request = 1'b1;
        send_mix(40, 10);
        drain();
    endtask

    // receiver: open, random or patterned ready, plus the long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                m_tready <= 1'b1;
            end
            else
            begin
                case (rx_mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_RANDOM: m_tready <= ($urandom_range(0, 99) >= 35);
                    default:   m_tready <= READY_PATTERN[rx_cycle % 11];
                endcase
            end
        end
    end

    // result checker: each output beat against the oldest predicted score
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_scores.size() == 0)
            begin
                $error("result beat with no score pending: energy %0d status %0d",
                       $signed(m_tdata), m_tuser);
                n_errors++;
            end
            else
            begin
                if (m_tdata !== pending_scores[0].energy)
                begin
                    $error("energy: expected %0d, got %0d", pending_scores[0].energy,
                           $signed(m_tdata));
                    n_errors++;
                end
                if (m_tuser !== pending_scores[0].status)
                begin
                    $error("status: expected %0d, got %0d", pending_scores[0].status,
                           m_tuser);
                    n_errors++;
                end
                case (pending_scores[0].status)
                    STATUS_SCORED: n_scored++;
                    STATUS_WINDOW: n_window++;
                    default:       n_deviation++;
                endcase
                n_checked++;
                void'(pending_scores.pop_front());
            end
        end
    end

    // watchdog: ends the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d scores pending", IDLE_LIMIT,
                     pending_scores.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        for (int k = 0; k < 3; k++)
            row_shadow[k] = '0;
        weight_shadow = WEIGHT_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_directed();
        test_weight_extremes();
        test_random_mix();
        test_backpressure();
        $display("run: %0d matrices in, %0d results checked, %0d register writes",
                 n_accepted, n_checked, n_reg_writes);
        $display("results: %0d scored, %0d outside window, %0d over deviation, %0d errors",
                 n_scored, n_window, n_deviation, n_errors);
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
